FILE: hw/rtl/binary_raster_aggregation_index_unit_assert.svh
// Assertion macros for the aggregation index unit.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef BINARY_RASTER_AGGREGATION_INDEX_UNIT_ASSERT_SVH
`define BINARY_RASTER_AGGREGATION_INDEX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BRAI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BRAI_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pre |=> post) else $error(msg);
`else
`define BRAI_ASSERT(lbl, prop, msg)
`define BRAI_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hw/rtl/brai_pkg.sv
// Shared constants for the binary raster aggregation index unit.
// No dependencies.
`timescale 1ns / 1ps
package brai_pkg;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_COLUMNS = 1024;

    localparam int CFG_W     = 11;
    localparam int IDX_W     = 17;
    localparam int OUT_W     = 21;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;
    localparam int IN_W      = 8;
    localparam int OUTD_W    = IDX_W + 3 * OUT_W;

    localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 11'd1024;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 11'd1024;

    // register index, taken from the word address bit
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;
endpackage

FILE: hw/rtl/binary_raster_aggregation_index_unit.sv
// Aggregation index of a streamed binary raster; one cell per word, rows fastest.
// After the last cell the result word is built by (count width + 1)/2 root steps, square,
// maximum, check, 17 divide steps and load; check and divide are skipped when the maximum is zero.
// Throughput: one cell per cycle inside a frame; ready stays low from the last cell until
// the result word loads. Reset: synchronous active low; counters clear, registers go to 1024.
// Depends on brai_pkg and binary_raster_aggregation_index_unit_assert.svh.
`timescale 1ns / 1ps
`include "binary_raster_aggregation_index_unit_assert.svh"
module binary_raster_aggregation_index_unit
    import brai_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [IN_W-1:0]    i_s_axis_tdata,   // [0] is_foreground
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [16:0] index_fraction, [37:17] cell_total, [58:38] edge_total, [79:59] edge_maximum
    output logic [OUTD_W-1:0]  o_m_axis_tdata,
    output logic [0:0]         o_m_axis_tuser,   // [0] undefined_flag
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int RCMP_W   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
    localparam int CCMP_W   = ($clog2(MAX_COLUMNS + 1) > CFG_W) ?
                              $clog2(MAX_COLUMNS + 1) : CFG_W;
    localparam int CNT_W    = $clog2(MAX_ROWS * MAX_COLUMNS + 1);
    localparam int EDGE_W   = CNT_W + 1;
    localparam int SQ_STEPS = (CNT_W + 1) / 2;
    localparam int RT_W     = SQ_STEPS;
    localparam int SQ_W     = 2 * SQ_STEPS;
    localparam int UW       = (SQ_W > EDGE_W + 1) ? SQ_W : EDGE_W + 1;
    localparam int MAX_STEP = (SQ_STEPS > IDX_W) ? SQ_STEPS : IDX_W;
    localparam int STEP_W   = $clog2(MAX_STEP + 1);

    localparam logic [IDX_W-1:0] INDEX_ONE = IDX_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SQRT, S_SQUARE, S_MAX, S_DCHK, S_DIV, S_DONE
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_row_count;
    logic [CFG_W-1:0]    r_column_count;
    logic [ROW_W-1:0]    r_row_pos;
    logic [ROW_W-1:0]    n_row_pos;
    logic [COL_W-1:0]    r_col_pos;
    logic [COL_W-1:0]    n_col_pos;
    logic                r_above;
    logic                r_left;
    logic [CNT_W-1:0]    r_fg;
    logic [EDGE_W-1:0]   r_edge;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_col_mem [MAX_ROWS];

    logic [CNT_W-1:0]    r_a;
    logic [EDGE_W-1:0]   r_g;
    logic [UW-1:0]       r_x;
    logic [UW-1:0]       r_root;
    logic [UW-1:0]       r_bit;
    logic [SQ_W-1:0]     r_nsq;
    logic [EDGE_W-1:0]   r_mx;
    logic [UW-1:0]       r_rem;
    logic [IDX_W-1:0]    r_quo;
    logic                r_flag;

    logic [RCMP_W-1:0]   w_rows;
    logic [CCMP_W-1:0]   w_cols;
    logic                w_acc;
    logic                w_bit;
    logic                w_row_last;
    logic                w_col_last;
    logic                w_frame_end;
    logic [1:0]          w_inc;
    logic [CNT_W-1:0]    w_fg_next;
    logic [EDGE_W-1:0]   w_edge_next;

    logic [UW-1:0]       u_a;
    logic [UW-1:0]       u_b;
    logic [UW:0]         u_diff;
    logic                u_ge;

    logic [EDGE_W-1:0]   w_n;
    logic [EDGE_W-1:0]   w_nsq;
    logic [EDGE_W-1:0]   w_m;
    logic [EDGE_W-1:0]   w_term;
    logic [EDGE_W-1:0]   n_mx;

    assign pready          = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_bit           = i_s_axis_tdata[0];

    always_comb begin
        unique case (paddr[ADDR_W-1])
            REG_ROW_COUNT:    prdata = APB_W'(r_row_count);
            REG_COLUMN_COUNT: prdata = APB_W'(r_column_count);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_row_count == '0) begin
            w_rows = RCMP_W'(1);
        end else if (RCMP_W'(r_row_count) > RCMP_W'(MAX_ROWS)) begin
            w_rows = RCMP_W'(MAX_ROWS);
        end else begin
            w_rows = RCMP_W'(r_row_count);
        end
        if (r_column_count == '0) begin
            w_cols = CCMP_W'(1);
        end else if (CCMP_W'(r_column_count) > CCMP_W'(MAX_COLUMNS)) begin
            w_cols = CCMP_W'(MAX_COLUMNS);
        end else begin
            w_cols = CCMP_W'(r_column_count);
        end
    end

    assign w_row_last  = (RCMP_W'(r_row_pos) + RCMP_W'(1)) >= w_rows;
    assign w_col_last  = (CCMP_W'(r_col_pos) + CCMP_W'(1)) >= w_cols;
    assign w_frame_end = w_row_last && w_col_last;
    assign w_inc       = {1'b0, w_bit && (r_row_pos != '0) && r_above}
                       + {1'b0, w_bit && (r_col_pos != '0) && r_left};
    assign w_fg_next   = r_fg + CNT_W'(w_bit);
    assign w_edge_next = r_edge + EDGE_W'(w_inc);

    always_comb begin
        n_row_pos = r_row_pos;
        n_col_pos = r_col_pos;
        if (w_acc) begin
            if (w_row_last) begin
                n_row_pos = '0;
                n_col_pos = w_col_last ? '0 : r_col_pos + COL_W'(1);
            end else begin
                n_row_pos = r_row_pos + ROW_W'(1);
            end
        end
    end

    // shared compare/subtract unit
    always_comb begin
        unique case (r_state)
            S_SQRT: begin
                u_a = r_x;
                u_b = r_root | r_bit;
            end
            S_DCHK: begin
                u_a = UW'(r_mx);
                u_b = UW'(r_g);
            end
            S_DIV: begin
                u_a = r_rem;
                u_b = UW'(r_mx);
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
    end
    assign u_diff = {1'b0, u_a} - {1'b0, u_b};
    assign u_ge   = !u_diff[UW];

    assign w_n    = EDGE_W'(r_root[RT_W-1:0]);
    assign w_nsq  = EDGE_W'(r_nsq);
    assign w_m    = EDGE_W'(r_a) - w_nsq;

    always_comb begin
        priority if (w_m == '0) begin
            w_term = '0;
        end else if (w_m <= w_n) begin
            w_term = (w_m << 1) - EDGE_W'(1);
        end else begin
            w_term = (w_m << 1) - EDGE_W'(2);
        end
    end
    assign n_mx = ((w_nsq - w_n) << 1) + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_row_count     <= ROW_COUNT_RESET;
            r_column_count  <= COLUMN_COUNT_RESET;
            r_row_pos       <= '0;
            r_col_pos       <= '0;
            r_above         <= 1'b0;
            r_fg            <= '0;
            r_edge          <= '0;
            r_cnt           <= '0;
            o_m_axis_tvalid <= 1'b0;
            o_m_axis_tdata  <= '0;
            o_m_axis_tuser  <= '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[ADDR_W-1])
                    REG_ROW_COUNT:    r_row_count    <= pwdata[CFG_W-1:0];
                    REG_COLUMN_COUNT: r_column_count <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_DONE)) begin
                o_m_axis_tvalid <= 1'b0;
            end
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_above <= w_row_last ? 1'b0 : w_bit;
                        if (w_frame_end) begin
                            r_fg    <= '0;
                            r_edge  <= '0;
                            r_cnt   <= STEP_W'(SQ_STEPS);
                            r_state <= S_SQRT;
                        end else begin
                            r_fg   <= w_fg_next;
                            r_edge <= w_edge_next;
                        end
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt - STEP_W'(1);
                    if (r_cnt == STEP_W'(1)) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: r_state <= S_MAX;
                S_MAX:    r_state <= (n_mx == '0) ? S_DONE : S_DCHK;
                S_DCHK: begin
                    r_cnt   <= STEP_W'(IDX_W);
                    r_state <= u_ge ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - STEP_W'(1);
                    if (r_cnt == STEP_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_m_axis_tvalid || i_m_axis_tready) begin
                        o_m_axis_tvalid <= 1'b1;
                        o_m_axis_tdata  <= {OUT_W'(r_mx), OUT_W'(r_g), OUT_W'(r_a), r_quo};
                        o_m_axis_tuser  <= r_flag;
                        r_state         <= S_IDLE;
                    end else begin
                        o_m_axis_tvalid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_frame_end) begin
                    r_a    <= w_fg_next;
                    r_g    <= w_edge_next;
                    r_x    <= UW'(w_fg_next);
                    r_root <= '0;
                    r_bit  <= UW'(1) << (SQ_W - 2);
                end
            end
            S_SQRT: begin
                if (u_ge) begin
                    r_x <= u_diff[UW-1:0];
                end
                r_root <= (r_root >> 1) | (u_ge ? r_bit : '0);
                r_bit  <= r_bit >> 2;
            end
            S_SQUARE: r_nsq <= r_root[RT_W-1:0] * r_root[RT_W-1:0];
            S_MAX: begin
                r_mx   <= n_mx;
                r_flag <= (n_mx == '0);
                r_quo  <= '0;
            end
            S_DCHK: begin
                r_rem <= UW'(r_g);
                if (!u_ge) begin
                    r_quo <= INDEX_ONE;
                end
            end
            S_DIV: begin
                r_quo <= {r_quo[IDX_W-2:0], u_ge};
                r_rem <= (u_ge ? u_diff[UW-1:0] : r_rem) << 1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // one-column store with read-ahead of the next row
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_col_mem[r_row_pos] <= w_bit;
        end
        if (w_acc && (n_row_pos == r_row_pos)) begin
            r_left <= w_bit;
        end else begin
            r_left <= r_col_mem[n_row_pos];
        end
    end

    `BRAI_ASSERT_NEXT(a_frame_end_clears, (w_acc && w_frame_end),
        (r_state == S_SQRT && r_fg == '0 && r_edge == '0 && r_col_pos == '0),
        "frame end did not start the pass")
    `BRAI_ASSERT(a_root_floor, (r_state == S_MAX) |-> (EDGE_W'(r_nsq) <= EDGE_W'(r_a)),
        "square of root exceeds count")
    `BRAI_ASSERT(a_div_rem, (r_state == S_DIV) |-> (r_rem < (UW'(r_mx) << 1)),
        "divide remainder out of range")
    `BRAI_ASSERT(a_flag_zero,
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[IDX_W-1:0] == '0),
        "flagged word has nonzero index")
    `BRAI_ASSERT(a_index_range, o_m_axis_tvalid |-> (o_m_axis_tdata[IDX_W-1:0] <= INDEX_ONE),
        "index above one")
endmodule
